>>> rtl/plm_pkg.sv
// Shared types and constants of the peak-to-peak level meter.
package plm_pkg;

  localparam int unsigned SAMPLE_WIDTH = 13;
  localparam int unsigned NUM_LEVELS   = 5;
  localparam int unsigned LEVEL_WIDTH  = 7;
  localparam int unsigned PROD_WIDTH   = SAMPLE_WIDTH + LEVEL_WIDTH;
  localparam int unsigned IDX_WIDTH    = $clog2(NUM_LEVELS);
  localparam int unsigned PADDR_WIDTH  = IDX_WIDTH + 2;
  localparam int unsigned PDATA_WIDTH  = 32;

  // Full scale of the percent levels
  localparam logic [LEVEL_WIDTH-1:0] PERCENT_FULL = LEVEL_WIDTH'(100);

  // Extreme sample values, used as the cleared min/max trackers
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
    signed'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    signed'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});

  // Register indexes (byte address / 4)
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_LEVEL1 = IDX_WIDTH'(0),
    REG_LEVEL2 = IDX_WIDTH'(1),
    REG_LEVEL3 = IDX_WIDTH'(2),
    REG_LEVEL4 = IDX_WIDTH'(3),
    REG_LEVEL5 = IDX_WIDTH'(4)
  } reg_idx_e;

  typedef logic [NUM_LEVELS-1:0][LEVEL_WIDTH-1:0] levels_t;

  localparam levels_t LEVEL_RESET = {
    LEVEL_WIDTH'(99), LEVEL_WIDTH'(80), LEVEL_WIDTH'(60),
    LEVEL_WIDTH'(40), LEVEL_WIDTH'(20)
  };

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           end_of_block;
  } in_req_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0]   bars;
    logic [SAMPLE_WIDTH-1:0] block_magnitude;
    logic [SAMPLE_WIDTH-1:0] peak_value;
  } out_rsp_t;

  // Block magnitude handed from the extremes stage to the bar stage
  typedef struct packed {
    logic                    valid;
    logic [SAMPLE_WIDTH-1:0] mag;
  } mag_req_t;

endpackage

>>> rtl/plm_cfg_regs.sv
// APB register file holding the five bar level percentages.
module plm_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [plm_pkg::PADDR_WIDTH-1:0]      paddr,
  input  logic [plm_pkg::PDATA_WIDTH-1:0]      pwdata,
  output logic [plm_pkg::PDATA_WIDTH-1:0]      prdata,
  output logic                                 pready,
  output plm_pkg::levels_t                     levels_o
);

  plm_pkg::levels_t                     levels_q, levels_d;
  plm_pkg::reg_idx_e                    idx;
  logic [plm_pkg::LEVEL_WIDTH-1:0]      rd_level;
  logic                                 wr_en;

  assign idx    = plm_pkg::reg_idx_e'(paddr[plm_pkg::PADDR_WIDTH-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write decode; addresses past the last level are ignored
  always_comb begin
    levels_d = levels_q;
    if (wr_en) begin
      unique case (idx)
        plm_pkg::REG_LEVEL1: levels_d[0] = pwdata[plm_pkg::LEVEL_WIDTH-1:0];
        plm_pkg::REG_LEVEL2: levels_d[1] = pwdata[plm_pkg::LEVEL_WIDTH-1:0];
        plm_pkg::REG_LEVEL3: levels_d[2] = pwdata[plm_pkg::LEVEL_WIDTH-1:0];
        plm_pkg::REG_LEVEL4: levels_d[3] = pwdata[plm_pkg::LEVEL_WIDTH-1:0];
        plm_pkg::REG_LEVEL5: levels_d[4] = pwdata[plm_pkg::LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      plm_pkg::REG_LEVEL1: rd_level = levels_q[0];
      plm_pkg::REG_LEVEL2: rd_level = levels_q[1];
      plm_pkg::REG_LEVEL3: rd_level = levels_q[2];
      plm_pkg::REG_LEVEL4: rd_level = levels_q[3];
      plm_pkg::REG_LEVEL5: rd_level = levels_q[4];
      default:             rd_level = '0;
    endcase
  end

  assign prdata   = plm_pkg::PDATA_WIDTH'(rd_level);
  assign levels_o = levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= plm_pkg::LEVEL_RESET;
    end else begin
      levels_q <= levels_d;
    end
  end

endmodule

>>> rtl/plm_extremes.sv
// Running min/max tracking and block magnitude register.
module plm_extremes (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plm_pkg::in_req_t  in_req_i,
  output plm_pkg::mag_req_t mag_o,
  input  logic              mag_ready_i
);

  logic signed [plm_pkg::SAMPLE_WIDTH-1:0] min_q, min_d, min_upd;
  logic signed [plm_pkg::SAMPLE_WIDTH-1:0] max_q, max_d, max_upd;
  logic                                    primed_q, primed_d;
  logic                                    valid_q, valid_d;
  logic [plm_pkg::SAMPLE_WIDTH-1:0]        mag_q, mag_d;
  logic                                    accept;

  // Stage is free when empty or being drained this cycle
  assign in_ready_o = !valid_q || mag_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign min_upd = (in_req_i.sample < min_q) ? in_req_i.sample : min_q;
  assign max_upd = (in_req_i.sample > max_q) ? in_req_i.sample : max_q;

  always_comb begin
    min_d    = min_q;
    max_d    = max_q;
    primed_d = primed_q;
    mag_d    = mag_q;
    valid_d  = valid_q && !mag_ready_i;
    if (accept) begin
      min_d = min_upd;
      max_d = max_upd;
      if (in_req_i.end_of_block) begin
        // Close the block: clear trackers, first block only primes
        min_d    = plm_pkg::SAMPLE_MAX;
        max_d    = plm_pkg::SAMPLE_MIN;
        primed_d = 1'b1;
        mag_d    = unsigned'(max_upd - min_upd);
        valid_d  = primed_q;
      end
    end
  end

  assign mag_o.valid = valid_q;
  assign mag_o.mag   = mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= plm_pkg::SAMPLE_MAX;
      max_q    <= plm_pkg::SAMPLE_MIN;
      primed_q <= 1'b0;
      valid_q  <= 1'b0;
      mag_q    <= '0;
    end else begin
      min_q    <= min_d;
      max_q    <= max_d;
      primed_q <= primed_d;
      valid_q  <= valid_d;
      mag_q    <= mag_d;
    end
  end

endmodule

>>> rtl/plm_bars.sv
// Peak update, percent comparisons and result register.
module plm_bars (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plm_pkg::mag_req_t  mag_i,
  output logic               mag_ready_o,
  input  plm_pkg::levels_t   levels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plm_pkg::out_rsp_t  out_rsp_o
);

  logic [plm_pkg::SAMPLE_WIDTH-1:0] peak_q, peak_new;
  logic [plm_pkg::PROD_WIDTH-1:0]   mag_scaled;
  logic [plm_pkg::NUM_LEVELS-1:0]   bars;
  logic                             valid_q, valid_d;
  plm_pkg::out_rsp_t                rsp_q, rsp_d;
  logic                             take;

  assign mag_ready_o = !valid_q || out_ready_i;
  assign take        = mag_i.valid && mag_ready_o;

  assign peak_new   = (mag_i.mag > peak_q) ? mag_i.mag : peak_q;
  assign mag_scaled = plm_pkg::PROD_WIDTH'(mag_i.mag) *
                      plm_pkg::PROD_WIDTH'(plm_pkg::PERCENT_FULL);

  // One comparison per bar: mag*100 > level*peak
  always_comb begin
    for (int k = 0; k < plm_pkg::NUM_LEVELS; k++) begin
      bars[k] = mag_scaled > (plm_pkg::PROD_WIDTH'(levels_i[k]) *
                              plm_pkg::PROD_WIDTH'(peak_new));
    end
  end

  always_comb begin
    rsp_d   = rsp_q;
    valid_d = valid_q && !out_ready_i;
    if (take) begin
      valid_d               = 1'b1;
      rsp_d.bars            = bars;
      rsp_d.block_magnitude = mag_i.mag;
      rsp_d.peak_value      = peak_new;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (take) begin
        peak_q <= peak_new;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

>>> rtl/block_peak_to_peak_level_meter.sv
// A closing sample's magnitude is registered in u_ext, then the result in u_bars.
// Throughput: one sample per cycle unless the result side stalls; min/max compare
// and peak/bar stages are each one register deep; either side may stall freely.
// Reset (async, active low): levels 20/40/60/80/99, trackers cleared, peak 0,
// first block after reset is discarded.
module block_peak_to_peak_level_meter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  plm_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output plm_pkg::out_rsp_t               out_rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plm_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [plm_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [plm_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                            pready
);

  plm_pkg::levels_t  levels;
  plm_pkg::mag_req_t mag;
  logic              mag_ready;

  plm_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .levels_o (levels)
  );

  plm_extremes u_ext (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .mag_o       (mag),
    .mag_ready_i (mag_ready)
  );

  plm_bars u_bars (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mag_i       (mag),
    .mag_ready_o (mag_ready),
    .levels_i    (levels),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the peak-to-peak level meter with its bar graph.
`timescale 1ns / 100ps

module tb;
  import plm_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_IDLE      = 17;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned NUM_ROWS      = 25;

  // Directed row: one sample plus an optional hand-written expected reading
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] smp;
    logic                    eob;
    logic                    typed;
    logic [NUM_LEVELS-1:0]   bars;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SAMPLE_WIDTH-1:0] peak;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // first block after reset is dropped
    '{13'd100,      1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{-13'sd5,      1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    // one-sample block while peak is still zero
    '{13'd7,        1'b1, 1'b1, 5'd0,  13'd0,    13'd0},
    // peak rises to 1000, every bar lights
    '{-13'sd300,    1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd700,      1'b1, 1'b1, 5'd31, 13'd1000, 13'd1000},
    // exactly on the lowest threshold: strict compare keeps it dark
    '{13'd0,        1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd200,      1'b1, 1'b1, 5'd0,  13'd200,  13'd1000},
    '{13'd0,        1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd201,      1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd10,       1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd1000,     1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd0,        1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd500,      1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    // full-scale swing
    '{13'h1000,     1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'h0fff,     1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd0,        1'b1, 1'b1, 5'd31, 13'd8191, 13'd8191},
    // single-sample blocks at both ends of the range
    '{13'h0fff,     1'b1, 1'b1, 5'd0,  13'd0,    13'd8191},
    '{13'h1000,     1'b1, 1'b1, 5'd0,  13'd0,    13'd8191},
    '{13'h0fff,     1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{-13'sd1,      1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'd1,        1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    // alternating bit patterns
    '{13'h0aaa,     1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'h1555,     1'b1, 1'b0, 5'd0,  13'd0,    13'd0},
    // two most negative values
    '{13'h1000,     1'b0, 1'b0, 5'd0,  13'd0,    13'd0},
    '{13'h1001,     1'b1, 1'b0, 5'd0,  13'd0,    13'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_req_t                in_req = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_rsp_t               out_rsp;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  // Meter state as predicted by the testbench
  logic signed [SAMPLE_WIDTH-1:0] trk_min = SAMPLE_MAX;
  logic signed [SAMPLE_WIDTH-1:0] trk_max = SAMPLE_MIN;
  logic [SAMPLE_WIDTH-1:0]        peak_mag = '0;
  bit                             warmed_up = 1'b0;
  logic [LEVEL_WIDTH-1:0]         level_pct [NUM_LEVELS];

  out_rsp_t    expected_readings [$];
  int unsigned mismatch_cnt = 0;
  bit          no_idle = 1'b0;
  int unsigned req_cnt = 0;
  int unsigned rsp_hold = 0;
  bit          rsp_taken = 1'b0;

  block_peak_to_peak_level_meter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Track min/max of the block; on its last sample form the bar reading
  function automatic bit meter_update(input in_req_t req, output out_rsp_t rsp);
    logic [SAMPLE_WIDTH-1:0] mag;
    rsp = '0;
    if (req.sample < trk_min) trk_min = req.sample;
    if (req.sample > trk_max) trk_max = req.sample;
    if (!req.end_of_block) return 1'b0;
    mag = SAMPLE_WIDTH'(trk_max - trk_min);
    trk_min = SAMPLE_MAX;
    trk_max = SAMPLE_MIN;
    if (!warmed_up) begin
      warmed_up = 1'b1;
      return 1'b0;
    end
    if (mag > peak_mag) peak_mag = mag;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (int'(mag) * 100 > int'(level_pct[k]) * int'(peak_mag)) rsp.bars[k] = 1'b1;
    end
    rsp.block_magnitude = mag;
    rsp.peak_value      = peak_mag;
    return 1'b1;
  endfunction

  // Send one sample; a typed reading overrides the predicted one
  task automatic send_sample(input in_req_t req, input bit typed, input out_rsp_t typed_rsp);
    int unsigned gap;
    out_rsp_t    rsp;
    if (req_cnt % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
    req_cnt++;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (meter_update(req, rsp)) expected_readings.push_back(typed ? typed_rsp : rsp);
  endtask

  // Random block: wide swings, narrow swings around a base, or flat
  task automatic send_random_block(output int unsigned len);
    int unsigned             mode;
    logic [SAMPLE_WIDTH-1:0] base;
    in_req_t                 req;
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    mode = $urandom_range(0, 2);
    base = SAMPLE_WIDTH'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       req.sample = SAMPLE_WIDTH'($urandom);
        1:       req.sample = base + SAMPLE_WIDTH'($urandom_range(0, 255));
        default: req.sample = base;
      endcase
      req.end_of_block = (i == len - 1);
      send_sample(req, 1'b0, '0);
    end
  endtask

  task automatic write_level(input reg_idx_e idx, input logic [LEVEL_WIDTH-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = PDATA_WIDTH'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    level_pct[idx] = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_level(input reg_idx_e idx);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_WIDTH'(level_pct[idx])) begin
      $error("prdata[%s]: expected %0d, got %0d", idx.name(), level_pct[idx], prdata);
      mismatch_cnt++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Let every pending reading come out, then give a dropped block time to settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result-side backpressure, redrawn after every accepted reading
  always @(negedge clk) begin
    if (rsp_taken) rsp_hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    out_ready = (rsp_hold == 0);
    if (rsp_hold != 0) rsp_hold--;
  end

  // Compare each accepted reading with the oldest expected one
  always @(posedge clk) begin : check_readings
    out_rsp_t want;
    rsp_taken <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: bars %0d, block_magnitude %0d, peak_value %0d",
               out_rsp.bars, out_rsp.block_magnitude, out_rsp.peak_value);
        mismatch_cnt++;
      end else begin
        want = expected_readings.pop_front();
        if (out_rsp.bars !== want.bars) begin
          $error("bars: expected %0d, got %0d", want.bars, out_rsp.bars);
          mismatch_cnt++;
        end
        if (out_rsp.block_magnitude !== want.block_magnitude) begin
          $error("block_magnitude: expected %0d, got %0d",
                 want.block_magnitude, out_rsp.block_magnitude);
          mismatch_cnt++;
        end
        if (out_rsp.peak_value !== want.peak_value) begin
          $error("peak_value: expected %0d, got %0d", want.peak_value, out_rsp.peak_value);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    in_req_t                req;
    out_rsp_t               typed_rsp;
    logic [LEVEL_WIDTH-1:0] lvl;
    int unsigned            sent;
    int unsigned            len;
    level_pct = '{LEVEL_RESET[0], LEVEL_RESET[1], LEVEL_RESET[2],
                  LEVEL_RESET[3], LEVEL_RESET[4]};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values of the levels
    for (int k = 0; k < NUM_LEVELS; k++) check_level(reg_idx_e'(k));

    // Directed part under the reset levels
    for (int r = 0; r < NUM_ROWS; r++) begin
      req.sample       = DIRECTED[r].smp;
      req.end_of_block = DIRECTED[r].eob;
      typed_rsp        = '{bars: DIRECTED[r].bars, block_magnitude: DIRECTED[r].mag,
                           peak_value: DIRECTED[r].peak};
      send_sample(req, DIRECTED[r].typed, typed_rsp);
    end

    // Random blocks under several level settings, extremes first
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      for (int k = 0; k < NUM_LEVELS; k++) begin
        case (p)
          0:       lvl = '0;
          1:       lvl = PERCENT_FULL;
          2:       lvl = '1;
          3:       lvl = LEVEL_WIDTH'(k * 25);
          default: lvl = LEVEL_WIDTH'($urandom_range(0, 127));
        endcase
        write_level(reg_idx_e'(k), lvl);
      end
      for (int k = 0; k < NUM_LEVELS; k++) check_level(reg_idx_e'(k));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_block(len);
        sent += len;
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
